[src/bgs_pkg.sv]
package bgs_pkg;

    // Fixed figures of the gauge
    localparam int TABLE_STEPS         = 15;
    localparam int SAMPLES_PER_READING = 12;
    localparam int VOTE_READS          = 8;
    localparam int QUEUE_DEPTH_DEF     = 2;

    localparam int TABLE_SIZE = 15;
    localparam int TABLE_USED = (TABLE_STEPS < TABLE_SIZE) ? TABLE_STEPS : TABLE_SIZE;
    localparam int VOTE_USED  = (VOTE_READS < 8) ? VOTE_READS : 8;

    localparam logic [14:0] PACK_MAX_MV = 15'd20000;
    localparam logic [6:0]  PCT_MAX     = 7'd99;
    localparam logic [3:0]  VOTE_NEEDED = 4'd5;

    // Divide by SAMPLES_PER_READING: reciprocal multiply, then one correction step
    localparam int          DIV_SHIFT = 16;
    localparam logic [16:0] DIV_RECIP = 17'((1 << DIV_SHIFT) / SAMPLES_PER_READING);
    localparam logic [6:0]  DIV_CONST = 7'(SAMPLES_PER_READING);

    localparam logic [14:0] SOC_MV [TABLE_SIZE] = '{
        15'd6000, 15'd6150, 15'd6300, 15'd6500, 15'd6700, 15'd6900, 15'd7100, 15'd7300,
        15'd7500, 15'd7700, 15'd7900, 15'd8050, 15'd8200, 15'd8350, 15'd8500
    };
    localparam logic [6:0] SOC_PCT [TABLE_SIZE] = '{
        7'd0, 7'd3, 7'd7, 7'd12, 7'd18, 7'd25, 7'd33, 7'd42,
        7'd50, 7'd58, 7'd68, 7'd76, 7'd84, 7'd92, 7'd99
    };

    // Configuration register indexes
    localparam logic [2:0] REG_ENABLE_MASK   = 3'd0;
    localparam logic [2:0] REG_DIVIDER_RATIO = 3'd1;
    localparam logic [2:0] REG_ACTIVE_INTVL  = 3'd2;
    localparam logic [2:0] REG_IDLE_INTVL    = 3'd3;
    localparam logic [2:0] REG_LOW_INTVL     = 3'd4;
    localparam logic [2:0] REG_LOW_ATTN_PCT  = 3'd5;
    localparam logic [2:0] REG_CHEERFUL_PCT  = 3'd6;
    localparam logic [2:0] REG_NORMAL_PCT    = 3'd7;

    localparam logic [1:0] MOOD_CHEERFUL = 2'd0;
    localparam logic [1:0] MOOD_NORMAL   = 2'd1;
    localparam logic [1:0] MOOD_LOW      = 2'd2;

    typedef struct packed {
        logic [1:0]  enable_mask;
        logic [15:0] divider_ratio_q12;
        logic [23:0] active_interval_ms;
        logic [23:0] idle_interval_ms;
        logic [23:0] low_interval_ms;
        logic [6:0]  low_attention_pct;
        logic [6:0]  cheerful_min_pct;
        logic [6:0]  normal_min_pct;
    } t_cfg;

    // Classified word handed from front to back
    typedef struct packed {
        logic        command;
        logic [31:0] now_ms;
        logic [23:0] interval_ms;
        logic [15:0] pin_mv;
        logic        vote;
    } t_item;

    typedef struct packed {
        logic [1:0]  mood;
        logic        charging;
        logic        ready_res;
        logic [6:0]  charge_pct;
        logic [14:0] smooth_mv;
        logic        sampled;
    } t_res;

    function automatic logic [6:0] lookup_pct(input logic [14:0] mv);
        logic [6:0] pct;
        logic       go;
        pct = SOC_PCT[0];
        go  = 1'b1;
        for (int i = 0; i < TABLE_USED; i++) begin
            if (go && mv >= SOC_MV[i]) begin
                pct = SOC_PCT[i];
            end else begin
                go = 1'b0;
            end
        end
        return (pct > PCT_MAX) ? PCT_MAX : pct;
    endfunction

endpackage

[src/bgs_front.sv]
module bgs_front import bgs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [31:0] i_now_ms,
    input  logic        i_active,
    input  logic [15:0] i_adc_sum_mv,
    input  logic [7:0]  i_charge_reads,
    input  logic        i_q_full,
    output logic        o_push,
    output t_item       o_item
);

    logic        r_v;
    logic        r_command;
    logic [31:0] r_now_ms;
    logic [23:0] r_interval;
    logic [15:0] r_sum;
    logic [15:0] r_quot;
    logic        r_vote;

    logic [32:0] prod;
    logic [23:0] interval_sel;
    logic [3:0]  ones;
    logic        vote_in;
    logic [22:0] back_mul;
    logic [16:0] remain;
    logic [15:0] pin;
    logic        take;

    assign o_ready = !r_v || !i_q_full;
    assign o_push  = r_v && !i_q_full;
    assign take    = i_valid && o_ready;

    always_comb begin
        prod = {17'd0, i_adc_sum_mv} * {16'd0, DIV_RECIP};
        interval_sel = (!i_active && (i_cfg.idle_interval_ms != 24'd0))
                     ? i_cfg.idle_interval_ms : i_cfg.active_interval_ms;
        ones = 4'd0;
        for (int i = 0; i < VOTE_USED; i++) begin
            ones = ones + {3'd0, i_charge_reads[i]};
        end
        vote_in = i_cfg.enable_mask[1] && (ones >= VOTE_NEEDED);
    end

    // estimate is at most one short
    always_comb begin
        back_mul = {7'd0, r_quot} * {16'd0, DIV_CONST};
        remain   = 17'({7'd0, r_sum} - back_mul);
        pin      = (remain >= {10'd0, DIV_CONST}) ? r_quot + 16'd1 : r_quot;
    end

    assign o_item = '{command: r_command, now_ms: r_now_ms, interval_ms: r_interval,
                      pin_mv: pin, vote: r_vote};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (take) begin
            r_v <= 1'b1;
        end else if (o_push) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_command  <= i_command;
            r_now_ms   <= i_now_ms;
            r_interval <= interval_sel;
            r_sum      <= i_adc_sum_mv;
            r_quot     <= prod[DIV_SHIFT +: 16];
            r_vote     <= vote_in;
        end
    end

endmodule

[src/bgs_queue.sv]
module bgs_queue import bgs_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[src/bgs_back.sv]
module bgs_back import bgs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_q_empty,
    input  t_item i_item,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_ready,
    output t_res  o_res
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEC  = 3'd1;
    localparam logic [2:0] ST_EMA  = 3'd2;
    localparam logic [2:0] ST_PCT  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  r_st;
    logic [2:0]  n_st;
    t_item       r_item;
    logic [31:0] r_prod;
    logic        r_smp;
    logic [31:0] r_last;
    logic [14:0] r_smooth;
    logic [6:0]  r_pct;
    logic        r_gvalid;
    logic        r_flag;
    logic        r_ovalid;
    t_res        r_res;

    logic [23:0] intvl;
    logic [31:0] elapsed;
    logic        do_smp;
    logic [32:0] rounded;
    logic [20:0] scaled;
    logic [14:0] pack;
    logic [17:0] ema_sum;
    logic [14:0] n_smooth;
    logic        out_load;
    logic [1:0]  mood;

    assign o_valid = r_ovalid;
    assign o_res   = r_res;

    always_comb begin
        intvl = r_item.interval_ms;
        if (r_gvalid && (r_pct < i_cfg.low_attention_pct)
            && (i_cfg.low_interval_ms != 24'd0) && (intvl > i_cfg.low_interval_ms)) begin
            intvl = i_cfg.low_interval_ms;
        end
        elapsed = r_item.now_ms - r_last;
        do_smp  = i_cfg.enable_mask[0] && (r_item.command || (elapsed >= {8'd0, intvl}));
    end

    always_comb begin
        rounded  = {1'b0, r_prod} + 33'd2048;
        scaled   = rounded[32:12];
        pack     = (scaled > {6'd0, PACK_MAX_MV}) ? PACK_MAX_MV : scaled[14:0];
        ema_sum  = ({3'd0, r_smooth} * 18'd7) + {3'd0, pack};
        n_smooth = r_gvalid ? ema_sum[17:3] : pack;
    end

    always_comb begin
        if (!i_cfg.enable_mask[0]) begin
            mood = MOOD_NORMAL;
        end else if (r_pct >= i_cfg.cheerful_min_pct) begin
            mood = MOOD_CHEERFUL;
        end else if (r_pct >= i_cfg.normal_min_pct) begin
            mood = MOOD_NORMAL;
        end else begin
            mood = MOOD_LOW;
        end
    end

    assign out_load = (r_st == ST_OUT) && (!r_ovalid || i_ready);

    always_comb begin
        n_st  = r_st;
        o_pop = 1'b0;
        case (r_st)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_st  = ST_DEC;
                end
            end
            ST_DEC: begin
                n_st = do_smp ? ST_EMA : ST_OUT;
            end
            ST_EMA: begin
                n_st = ST_PCT;
            end
            ST_PCT: begin
                n_st = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    if (!i_q_empty) begin
                        o_pop = 1'b1;
                        n_st  = ST_DEC;
                    end else begin
                        n_st = ST_IDLE;
                    end
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_last   <= '0;
            r_smooth <= '0;
            r_pct    <= '0;
            r_gvalid <= 1'b0;
            r_flag   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_EMA) begin
                r_smooth <= n_smooth;
                r_gvalid <= 1'b1;
                r_flag   <= r_item.vote;
                r_last   <= r_item.now_ms;
            end
            if (r_st == ST_PCT) begin
                r_pct <= lookup_pct(r_smooth);
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (r_st == ST_DEC) begin
            r_prod <= {16'd0, r_item.pin_mv} * {16'd0, i_cfg.divider_ratio_q12};
            r_smp  <= do_smp;
        end
        if (out_load) begin
            r_res <= '{mood: mood,
                       charging: r_flag && i_cfg.enable_mask[1],
                       ready_res: i_cfg.enable_mask[0] && r_gvalid,
                       charge_pct: r_pct,
                       smooth_mv: r_smooth,
                       sampled: r_smp};
        end
    end

endmodule

[src/battery_gauge_sampler.sv]
// Channel   Dir  Word                 Fields, lowest bit first
// s_axis    in   item                 tdata: now_ms, active, adc_sum_mv, charge_reads
//                                     tuser: command
// m_axis    out  result               tdata: sampled, smooth_mv, charge_pct, ready_res,
//                                            charging, mood
// i_cfg_*   in   register write       index 0..7, data up to 24 bits
//
// Front: one register stage (divide by readings, vote, interval pick) into a short queue.
// Back: one item at a time, through decide+scale multiply, EMA, table lookup and output load
// for a sample, or decide and output load when no sample is taken.
// Sync active-low reset clears the gauge state, the queue and both valid flags.
// The front keeps accepting while the queue has room; a stalled output holds the back.
module battery_gauge_sampler import bgs_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // now_ms, active, adc_sum_mv, charge_reads
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // sampled, smooth_mv, charge_pct, ready_res, charging, mood
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_wdata
);

    t_cfg  r_cfg;
    t_item front_item;
    t_item head_item;
    t_res  res;
    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{enable_mask: 2'd3, divider_ratio_q12: 16'd8192,
                       active_interval_ms: 24'd5000, idle_interval_ms: 24'd30000,
                       low_interval_ms: 24'd2000, low_attention_pct: 7'd20,
                       cheerful_min_pct: 7'd50, normal_min_pct: 7'd20};
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ENABLE_MASK:   r_cfg.enable_mask        <= i_cfg_wdata[1:0];
                REG_DIVIDER_RATIO: r_cfg.divider_ratio_q12  <= i_cfg_wdata[15:0];
                REG_ACTIVE_INTVL:  r_cfg.active_interval_ms <= i_cfg_wdata;
                REG_IDLE_INTVL:    r_cfg.idle_interval_ms   <= i_cfg_wdata;
                REG_LOW_INTVL:     r_cfg.low_interval_ms    <= i_cfg_wdata;
                REG_LOW_ATTN_PCT:  r_cfg.low_attention_pct  <= i_cfg_wdata[6:0];
                REG_CHEERFUL_PCT:  r_cfg.cheerful_min_pct   <= i_cfg_wdata[6:0];
                REG_NORMAL_PCT:    r_cfg.normal_min_pct     <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    bgs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_command      (s_axis_tuser),
        .i_now_ms       (s_axis_tdata[31:0]),
        .i_active       (s_axis_tdata[32]),
        .i_adc_sum_mv   (s_axis_tdata[48:33]),
        .i_charge_reads (s_axis_tdata[56:49]),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_item         (front_item)
    );

    bgs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    bgs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_item    (head_item),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (res)
    );

    assign m_axis_tdata = {5'd0, res};

endmodule

[tb/sv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bgs_pkg::*;

    // state-of-charge step table: pack mV threshold and percent
    localparam int unsigned STEP_MV [15] = '{
        6000, 6150, 6300, 6500, 6700, 6900, 7100, 7300,
        7500, 7700, 7900, 8050, 8200, 8350, 8500
    };
    localparam int unsigned STEP_PCT [15] = '{
        0, 3, 7, 12, 18, 25, 33, 42, 50, 58, 68, 76, 84, 92, 99
    };

    class gauge_scoreboard;
        logic [1:0]  en_mask;
        logic [15:0] ratio_q12;
        logic [23:0] active_ms;
        logic [23:0] idle_ms;
        logic [23:0] low_ms;
        logic [6:0]  low_attn;
        logic [6:0]  cheer_min;
        logic [6:0]  normal_min;

        logic [31:0] last_t;
        logic [14:0] smooth_mv;
        logic [6:0]  pct;
        logic        seeded;
        logic        chg_flag;

        t_res expected_readings[$];
        int   errors;

        function new();
            en_mask    = 2'd3;
            ratio_q12  = 16'd8192;
            active_ms  = 24'd5000;
            idle_ms    = 24'd30000;
            low_ms     = 24'd2000;
            low_attn   = 7'd20;
            cheer_min  = 7'd50;
            normal_min = 7'd20;
            last_t     = '0;
            smooth_mv  = '0;
            pct        = '0;
            seeded     = 1'b0;
            chg_flag   = 1'b0;
            errors     = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [23:0] v);
            case (idx)
                REG_ENABLE_MASK:   en_mask    = v[1:0];
                REG_DIVIDER_RATIO: ratio_q12  = v[15:0];
                REG_ACTIVE_INTVL:  active_ms  = v;
                REG_IDLE_INTVL:    idle_ms    = v;
                REG_LOW_INTVL:     low_ms     = v;
                REG_LOW_ATTN_PCT:  low_attn   = v[6:0];
                REG_CHEERFUL_PCT:  cheer_min  = v[6:0];
                REG_NORMAL_PCT:    normal_min = v[6:0];
                default: ;
            endcase
        endfunction

        function logic [6:0] soc_percent(int unsigned mv);
            int unsigned p;
            p = STEP_PCT[0];
            // thresholds ascend, so the last one passed wins
            for (int i = 0; i < 15; i++) begin
                if (mv >= STEP_MV[i]) p = STEP_PCT[i];
            end
            return (p > 99) ? 7'd99 : 7'(p);
        endfunction

        function void take_sample(logic [15:0] adc, logic [7:0] reads);
            int unsigned pin;
            int unsigned scaled;
            int unsigned pack;
            pin    = adc / 12;
            scaled = (pin * ratio_q12 + 2048) >> 12;
            pack   = (scaled > 20000) ? 20000 : scaled;
            if (!seeded) begin
                smooth_mv = 15'(pack);
            end else begin
                smooth_mv = 15'((32'(smooth_mv) * 7 + pack) / 8);
            end
            pct      = soc_percent(smooth_mv);
            chg_flag = en_mask[1] && ($countones(reads) >= 5);
            seeded   = 1'b1;
        endfunction

        function void note_item(bit cmd, logic [31:0] now, bit act, logic [15:0] adc,
                                logic [7:0] reads);
            t_res        r;
            logic [23:0] iv;
            logic [31:0] elapsed;
            r.sampled = 1'b0;
            if (en_mask[0]) begin
                if (cmd) begin
                    take_sample(adc, reads);
                    last_t    = now;
                    r.sampled = 1'b1;
                end else begin
                    iv = (!act && idle_ms != 0) ? idle_ms : active_ms;
                    if (seeded && pct < low_attn && low_ms != 0 && iv > low_ms) iv = low_ms;
                    elapsed = now - last_t;
                    if (elapsed >= {8'd0, iv}) begin
                        last_t = now;
                        take_sample(adc, reads);
                        r.sampled = 1'b1;
                    end
                end
            end
            r.smooth_mv  = smooth_mv;
            r.charge_pct = pct;
            r.ready_res  = en_mask[0] && seeded;
            r.charging   = chg_flag && en_mask[1];
            if (!en_mask[0]) begin
                r.mood = MOOD_NORMAL;
            end else if (pct >= cheer_min) begin
                r.mood = MOOD_CHEERFUL;
            end else if (pct >= normal_min) begin
                r.mood = MOOD_NORMAL;
            end else begin
                r.mood = MOOD_LOW;
            end
            expected_readings.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_reading(logic [31:0] word);
            t_res got;
            t_res want;
            got = word[26:0];
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected word, expected none actual %h", $time, word);
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            compare_field("sampled", want.sampled, got.sampled);
            compare_field("smooth_mv", want.smooth_mv, got.smooth_mv);
            compare_field("charge_pct", want.charge_pct, got.charge_pct);
            compare_field("ready_res", want.ready_res, got.ready_res);
            compare_field("charging", want.charging, got.charging);
            compare_field("mood", want.mood, got.mood);
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // now_ms, active, adc_sum_mv, charge_reads
    logic        s_axis_tuser = 1'b0; // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // sampled, smooth_mv, charge_pct, ready_res, charging, mood
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [23:0] i_cfg_wdata = '0;

    gauge_scoreboard gauge_sb;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          rx_hold_cycles = 0;
    logic [31:0] sim_ms = '0;
    int          base_adc = 0;

    battery_gauge_sampler DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random back-pressure, plus one long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
                m_axis_tready <= 1'b1;
            end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) gauge_sb.check_reading(m_axis_tdata);
    end

    // valid stays high after a word is taken; a gap or drain lowers it
    task automatic send_item(bit cmd, logic [31:0] now, bit act, logic [15:0] adc,
                             logic [7:0] reads);
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, reads, adc, act, now};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        gauge_sb.note_item(cmd, now, act, adc, reads);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (gauge_sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [23:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        gauge_sb.set_register(idx, v);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_interval();
        case ($urandom_range(0, 7))
            0:       return 24'd0;
            1:       return 24'hFF_FFFF;
            default: return 24'($urandom_range(1, 400));
        endcase
    endfunction

    task automatic random_config();
        logic [1:0]  en;
        logic [15:0] ratio;
        case ($urandom_range(0, 7))
            0:       en = 2'd0;
            1:       en = 2'd1;
            2:       en = 2'd2;
            default: en = 2'd3;
        endcase
        case ($urandom_range(0, 7))
            0:       ratio = 16'd0;
            1:       ratio = 16'hFFFF;
            2:       ratio = 16'd8192;
            3:       ratio = 16'd12288;
            4:       ratio = 16'd16384;
            default: ratio = 16'($urandom_range(4096, 24576));
        endcase
        cfg_write(REG_ENABLE_MASK, {22'd0, en});
        cfg_write(REG_DIVIDER_RATIO, {8'd0, ratio});
        cfg_write(REG_ACTIVE_INTVL, pick_interval());
        cfg_write(REG_IDLE_INTVL, pick_interval());
        cfg_write(REG_LOW_INTVL, pick_interval());
        cfg_write(REG_LOW_ATTN_PCT, 24'($urandom_range(0, 100)));
        cfg_write(REG_CHEERFUL_PCT, 24'($urandom_range(0, 100)));
        cfg_write(REG_NORMAL_PCT, 24'($urandom_range(0, 100)));
        // aim the ADC level at the table span most of the time
        if (ratio != 0 && $urandom_range(0, 3) != 0) begin
            base_adc = int'((5500 + $urandom_range(0, 3500)) * 49152 / ratio);
        end else begin
            base_adc = $urandom_range(0, 39600);
        end
        if (base_adc > 39600) base_adc = 39600;
    endtask

    task automatic random_item();
        bit         cmd;
        int         lvl;
        logic [15:0] adc;
        cmd = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 15) == 0) begin
            sim_ms = $urandom();
        end else begin
            sim_ms = sim_ms + $urandom_range(0, 500);
        end
        base_adc = base_adc + int'($urandom_range(0, 400)) - 200;
        if (base_adc < 0) base_adc = 0;
        if (base_adc > 39600) base_adc = 39600;
        case ($urandom_range(0, 7))
            0:       adc = 16'($urandom_range(0, 65535));
            1, 2:    adc = 16'($urandom_range(0, 39600));
            default: begin
                lvl = base_adc + int'($urandom_range(0, 600)) - 300;
                if (lvl < 0) lvl = 0;
                if (lvl > 39600) lvl = 39600;
                adc = 16'(lvl);
            end
        endcase
        send_item(cmd, sim_ms, 1'($urandom_range(0, 1)), adc, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        logic [31:0] t0;
        gauge_sb = new();
        t0 = 32'h8000_0000;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings; low interval must not apply before the first sample
        send_item(1'b0, 32'd0, 1'b1, 16'd0, 8'h00);
        send_item(1'b0, 32'd4999, 1'b1, 16'd39600, 8'hFF);
        send_item(1'b0, 32'd5000, 1'b1, 16'd39600, 8'hFF);
        send_item(1'b0, 32'd6999, 1'b0, 16'd0, 8'h0F);
        send_item(1'b0, 32'd7000, 1'b0, 16'd0, 8'h1F);
        send_item(1'b1, 32'hFFFF_FF00, 1'b1, 16'hFFFF, 8'hF0);
        // elapsed time wraps through zero
        send_item(1'b0, 32'h0000_06CF, 1'b1, 16'd24000, 8'hAA);
        send_item(1'b0, 32'h0000_06D0, 1'b1, 16'd24000, 8'h55);

        drain();
        cfg_write(REG_DIVIDER_RATIO, 24'hFFFF);
        cfg_write(REG_ENABLE_MASK, 24'd1);
        send_item(1'b1, t0, 1'b1, 16'd39600, 8'hFF);
        send_item(1'b1, t0, 1'b0, 16'd0, 8'hFF);
        drain();
        cfg_write(REG_ACTIVE_INTVL, 24'd0);
        cfg_write(REG_IDLE_INTVL, 24'd0);
        send_item(1'b0, t0, 1'b0, 16'd30000, 8'hFE);
        send_item(1'b0, t0, 1'b1, 16'd20000, 8'h7F);
        drain();
        cfg_write(REG_ENABLE_MASK, 24'd0);
        send_item(1'b1, t0 + 1, 1'b1, 16'd12000, 8'hFF);
        send_item(1'b0, t0 + 2, 1'b1, 16'd12000, 8'hFF);
        drain();
        cfg_write(REG_ENABLE_MASK, 24'd3);
        cfg_write(REG_DIVIDER_RATIO, 24'd0);
        cfg_write(REG_ACTIVE_INTVL, 24'hFF_FFFF);
        cfg_write(REG_IDLE_INTVL, 24'hFF_FFFF);
        cfg_write(REG_LOW_INTVL, 24'hFF_FFFF);
        cfg_write(REG_LOW_ATTN_PCT, 24'd100);
        cfg_write(REG_CHEERFUL_PCT, 24'd100);
        cfg_write(REG_NORMAL_PCT, 24'd100);
        send_item(1'b0, t0 + 32'h00FF_FFFE, 1'b1, 16'd9000, 8'h00);
        send_item(1'b0, t0 + 32'h00FF_FFFF, 1'b0, 16'd9000, 8'h00);
        drain();
        cfg_write(REG_CHEERFUL_PCT, 24'd0);
        cfg_write(REG_NORMAL_PCT, 24'd0);
        send_item(1'b1, t0, 1'b1, 16'd1000, 8'h1F);
        drain();
        cfg_write(REG_CHEERFUL_PCT, 24'd100);
        send_item(1'b1, t0, 1'b1, 16'd1000, 8'hE0);

        for (int phase = 0; phase < 12; phase++) begin
            drain();
            random_config();
            sim_ms = $urandom();
            if (phase >= 10 || phase == 2) begin
                tx_idle_pct = 0;
            end else begin
                tx_idle_pct = (phase % 3 == 0) ? 0 : 30;
            end
            rx_idle_pct = (phase >= 10 || phase % 4 == 3) ? 0 : 5 * (1 + phase % 3);
            // long output stall while words keep coming, so the input backs up
            if (phase == 2) rx_hold_cycles = 400;
            for (int n = 0; n < 150; n++) begin
                if (phase == 5 && n == 75) drain();
                random_item();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (gauge_sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
